// File: rtl/wsfe_pkg.sv
// Types and helpers shared by the WebSocket frame encoder modules.
// No dependencies.
package wsfe_pkg;

    localparam int HDR_BYTES = 8;
    localparam logic [6:0] SHORT_MAX = 7'd125;
    localparam logic [6:0] EXT16_CODE = 7'd126;
    localparam logic ITEM_BEGIN = 1'b0;
    localparam logic ITEM_PAYLOAD = 1'b1;

    // One run of bytes waiting to go out, built when an item is accepted.
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] bytes;
        logic [2:0]                last_idx;
        logic                      frame_end;
    } run_t;

    // Key byte at position idx, the first transmitted byte in bits 31 to 24.
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: rtl/wsfe_hdr_build.sv
// Combinational builder of the frame header run for a begin item.
// Depends on wsfe_pkg.
module wsfe_hdr_build
    import wsfe_pkg::*;
(
    input  logic [3:0]  frame_type,
    input  logic        final_fragment,
    input  logic        use_mask,
    input  logic [15:0] len,
    input  logic [31:0] mask_key,
    output run_t        run
);

    logic is_short;

    assign is_short = (len <= {9'd0, SHORT_MAX});

    always_comb
    begin
        run = '0;
        run.bytes[0] = {final_fragment, 3'b000, frame_type};
        if (is_short)
        begin
            run.bytes[1] = {use_mask, len[6:0]};
            run.bytes[2] = key_byte(mask_key, 2'd0);
            run.bytes[3] = key_byte(mask_key, 2'd1);
            run.bytes[4] = key_byte(mask_key, 2'd2);
            run.bytes[5] = key_byte(mask_key, 2'd3);
            run.last_idx = use_mask ? 3'd5 : 3'd1;
        end
        else
        begin
            run.bytes[1] = {use_mask, EXT16_CODE};
            run.bytes[2] = len[15:8];
            run.bytes[3] = len[7:0];
            run.bytes[4] = key_byte(mask_key, 2'd0);
            run.bytes[5] = key_byte(mask_key, 2'd1);
            run.bytes[6] = key_byte(mask_key, 2'd2);
            run.bytes[7] = key_byte(mask_key, 2'd3);
            run.last_idx = use_mask ? 3'd7 : 3'd3;
        end
        // An empty frame ends on its last header byte.
        run.frame_end = (len == 16'd0);
    end

endmodule

// File: rtl/websocket_frame_encoder_top.sv
// Top level of the WebSocket frame encoder: frame state, byte run buffer, output register.
// Depends on wsfe_pkg and wsfe_hdr_build.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, item_kind .. payload  | into block
//  output  | out_valid, out_ready, out_byte, run_last, | out of block
//          | frame_last                                |
//
// A payload item makes a one-byte run, and one transfer is accepted every cycle while
// the output drains. A begin item gives a header of 2 to 8 bytes, one per cycle
// from the run buffer, so the next item waits until the last header byte moves out.
// Reset clears the frame state and all valid flags. A stall on the output holds the
// output register and, once the run buffer is full, the input side too.
module websocket_frame_encoder_top
    import wsfe_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        item_kind,
    input  logic [3:0]  frame_type,
    input  logic        final_fragment,
    input  logic        use_mask,
    input  logic [15:0] payload_length,
    input  logic [31:0] mask_key,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        frame_last
);

    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             key_idx_reg, key_idx_next;
    logic                   masking_reg, masking_next;

    logic                   run_valid_reg, run_valid_next;
    run_t                   run_reg, run_next;
    logic [2:0]             run_idx_reg, run_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   run_last_reg, run_last_next;
    logic                   frame_last_reg, frame_last_next;

    logic [15:0]            len;
    run_t                   hdr_run;
    logic                   accept;
    logic                   out_load;
    logic                   run_at_end;
    logic [LENGTH_BITS-1:0] remaining_dec;
    logic [7:0]             masked_byte;

    assign len = {{(16-LENGTH_BITS){1'b0}}, payload_length[LENGTH_BITS-1:0]};

    wsfe_hdr_build u_hdr_build (
        .frame_type     (frame_type),
        .final_fragment (final_fragment),
        .use_mask       (use_mask),
        .len            (len),
        .mask_key       (mask_key),
        .run            (hdr_run)
    );

    assign out_load   = run_valid_reg && (!out_valid_reg || out_ready);
    assign run_at_end = (run_idx_reg == run_reg.last_idx);
    assign in_ready   = !run_valid_reg || (run_at_end && out_load);
    assign accept     = in_valid && in_ready;

    assign remaining_dec = remaining_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign masked_byte   = masking_reg ? (payload_byte ^ key_byte(key_reg, key_idx_reg))
                                       : payload_byte;

    always_comb
    begin
        remaining_next = remaining_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;
        masking_next   = masking_reg;
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        run_idx_next   = run_idx_reg;

        if (out_load)
        begin
            if (run_at_end)
                run_valid_next = 1'b0;
            else
                run_idx_next = run_idx_reg + 3'd1;
        end

        if (accept)
        begin
            if (item_kind == ITEM_BEGIN)
            begin
                // A new begin simply replaces whatever frame was still open.
                remaining_next = len[LENGTH_BITS-1:0];
                key_next       = mask_key;
                key_idx_next   = 2'd0;
                masking_next   = use_mask;
                run_valid_next = 1'b1;
                run_next       = hdr_run;
                run_idx_next   = 3'd0;
            end
            else if (remaining_reg != '0)
            begin
                remaining_next     = remaining_dec;
                key_idx_next       = key_idx_reg + 2'd1;
                run_valid_next     = 1'b1;
                run_next           = '0;
                run_next.bytes[0]  = masked_byte;
                run_next.last_idx  = 3'd0;
                run_next.frame_end = (remaining_dec == '0);
                run_idx_next       = 3'd0;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        frame_last_next = frame_last_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = run_reg.bytes[run_idx_reg];
            run_last_next   = run_at_end;
            frame_last_next = run_at_end && run_reg.frame_end;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
            masking_reg   <= 1'b0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
            masking_reg   <= masking_next;
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg        <= run_next;
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        frame_last_reg <= frame_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

endmodule
